/* rtl/tpzp_pkg.sv */
// ----------------------------------------------------------------------------
// tpzp_pkg
// Shared types, constants and the shade table for the torus point plotter.
// ----------------------------------------------------------------------------
package tpzp_pkg;

  localparam int TRIG_W  = 16;
  localparam int CELL_W  = 11;
  localparam int CHAR_W  = 7;
  localparam int DEPTH_W = 16;
  localparam int VW      = 40;   // working value width
  localparam int MAW     = 36;   // multiplier operand a
  localparam int MBW     = 24;   // multiplier operand b
  localparam int PW      = MAW + MBW;
  localparam int DIVW    = 34;   // dividend / divisor width
  localparam int STEP_W  = 5;

  localparam logic [CHAR_W-1:0] SPACE_CODE = 7'd32;

  typedef enum logic [1:0] {
    OP_PLOT  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    FIN_ZERO  = 2'd0,
    FIN_PLOT  = 2'd1,
    FIN_CLEAR = 2'd2,
    FIN_READ  = 2'd3
  } fin_kind_t;

  // multiply steps of the plot sequence
  localparam logic [STEP_W-1:0] STEP_CH        = 5'd0;
  localparam logic [STEP_W-1:0] STEP_CD        = 5'd1;
  localparam logic [STEP_W-1:0] STEP_FE        = 5'd2;
  localparam logic [STEP_W-1:0] STEP_FG        = 5'd3;
  localparam logic [STEP_W-1:0] STEP_LH        = 5'd4;
  localparam logic [STEP_W-1:0] STEP_LD        = 5'd5;
  localparam logic [STEP_W-1:0] STEP_CHE       = 5'd6;
  localparam logic [STEP_W-1:0] STEP_CHG       = 5'd7;
  localparam logic [STEP_W-1:0] STEP_CDG       = 5'd8;
  localparam logic [STEP_W-1:0] STEP_CDE       = 5'd9;
  localparam logic [STEP_W-1:0] STEP_LDN       = 5'd10;
  localparam logic [STEP_W-1:0] STEP_LHM       = 5'd11;
  localparam logic [STEP_W-1:0] STEP_LHN       = 5'd12;
  localparam logic [STEP_W-1:0] STEP_TN        = 5'd13;
  localparam logic [STEP_W-1:0] STEP_TM        = 5'd14;
  localparam logic [STEP_W-1:0] STEP_FCDM      = 5'd15;
  localparam logic [STEP_W-1:0] STEP_DRAIN_A   = 5'd16;
  localparam logic [STEP_W-1:0] STEP_RDX       = 5'd17;
  localparam logic [STEP_W-1:0] STEP_RDY       = 5'd18;
  localparam logic [STEP_W-1:0] STEP_PX        = 5'd19;
  localparam logic [STEP_W-1:0] STEP_PY        = 5'd20;
  localparam logic [STEP_W-1:0] STEP_END       = 5'd22;
  localparam logic [STEP_W-1:0] STEP_DIV_START = STEP_CDG;

  localparam logic [2:0] REG_ROT_A_SINE   = 3'd0;
  localparam logic [2:0] REG_ROT_A_COSINE = 3'd1;
  localparam logic [2:0] REG_ROT_B_SINE   = 3'd2;
  localparam logic [2:0] REG_ROT_B_COSINE = 3'd3;
  localparam logic [2:0] REG_COL_OFFSET   = 3'd4;
  localparam logic [2:0] REG_COL_RADIUS   = 3'd5;
  localparam logic [2:0] REG_ROW_OFFSET   = 3'd6;
  localparam logic [2:0] REG_ROW_RADIUS   = 3'd7;

  typedef struct packed {
    logic signed [TRIG_W-1:0] a_sin;
    logic signed [TRIG_W-1:0] a_cos;
    logic signed [TRIG_W-1:0] b_sin;
    logic signed [TRIG_W-1:0] b_cos;
    logic [5:0]               col_off;
    logic [5:0]               col_rad;
    logic [4:0]               row_off;
    logic [4:0]               row_rad;
  } cfg_t;

  typedef struct packed {
    logic              load;
    logic              issue;
    logic [STEP_W-1:0] step;
    logic              div_start;
    logic              sweep;
    logic              rd;
    logic              fin;
    fin_kind_t         kind;
  } dp_cmd_t;

  typedef struct packed {
    logic den_pos;
    logic div_done;
    logic cell_ok;
    logic sweep_last;
    logic out_free;
  } dp_stat_t;

  function automatic logic [CHAR_W-1:0] shade_char(input logic [3:0] idx);
    logic [CHAR_W-1:0] ch;
    unique case (idx)
      4'd0:    ch = 7'd46;   // .
      4'd1:    ch = 7'd44;   // ,
      4'd2:    ch = 7'd45;   // -
      4'd3:    ch = 7'd126;  // ~
      4'd4:    ch = 7'd58;   // :
      4'd5:    ch = 7'd59;   // ;
      4'd6:    ch = 7'd61;   // =
      4'd7:    ch = 7'd33;   // !
      4'd8:    ch = 7'd42;   // *
      4'd9:    ch = 7'd35;   // #
      4'd10:   ch = 7'd36;   // $
      default: ch = 7'd64;   // @
    endcase
    return ch;
  endfunction

endpackage

/* rtl/tpzp_ifs.sv */
// ----------------------------------------------------------------------------
// tpzp_ifs
// Valid/ready channels for torus samples and plot results.
// ----------------------------------------------------------------------------
interface tpzp_sample_if import tpzp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               opcode;
  logic signed [TRIG_W-1:0] tube_sine;
  logic signed [TRIG_W-1:0] tube_cosine;
  logic signed [TRIG_W-1:0] ring_sine;
  logic signed [TRIG_W-1:0] ring_cosine;
  logic [CELL_W-1:0]        cell_index;

  modport source (output valid, opcode, tube_sine, tube_cosine, ring_sine, ring_cosine,
                  cell_index, input ready);
  modport sink (input valid, opcode, tube_sine, tube_cosine, ring_sine, ring_cosine,
                cell_index, output ready);
endinterface

interface tpzp_result_if import tpzp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               plotted;
  logic [CELL_W-1:0]  target_cell;
  logic [CHAR_W-1:0]  char_code;
  logic [DEPTH_W-1:0] cell_depth;

  modport source (output valid, plotted, target_cell, char_code, cell_depth, input ready);
  modport sink (input valid, plotted, target_cell, char_code, cell_depth, output ready);
endinterface

/* rtl/tpzp_div.sv */
// ----------------------------------------------------------------------------
// tpzp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tpzp_div import tpzp_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [DIVW-1:0] num,
  input  logic [DIVW-1:0] den,
  output logic [DIVW-1:0] quo,
  output logic            done
);

  localparam int CW = $clog2(DIVW + 1);

  logic [DIVW:0]   rem;
  logic [DIVW:0]   rem_sh;
  logic [DIVW+1:0] diff;
  logic [CW-1:0]   cnt;

  assign rem_sh = {rem[DIVW-1:0], quo[DIVW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CW'(DIVW);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (cnt != '0) begin
      if (!diff[DIVW+1]) begin
        rem <= diff[DIVW:0];
        quo <= {quo[DIVW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[DIVW-2:0], 1'b0};
      end
    end
  end

endmodule

/* rtl/tpzp_dp.sv */
// ----------------------------------------------------------------------------
// tpzp_dp
// Datapath: shared multiplier, divider, cell store and result register.
// ----------------------------------------------------------------------------
module tpzp_dp import tpzp_pkg::*; #(
  parameter int COLUMNS        = 50,
  parameter int ROWS           = 22,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  cmd,
  output dp_stat_t                 stat,
  input  cfg_t                     cfg,
  input  logic signed [TRIG_W-1:0] tube_sine,
  input  logic signed [TRIG_W-1:0] tube_cosine,
  input  logic signed [TRIG_W-1:0] ring_sine,
  input  logic signed [TRIG_W-1:0] ring_cosine,
  input  logic [CELL_W-1:0]        cell_index,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic                     plotted,
  output logic [CELL_W-1:0]        target_cell,
  output logic [CHAR_W-1:0]        char_code,
  output logic [DEPTH_W-1:0]       cell_depth
);

  localparam int T     = TRIG_FRAC_BITS;
  localparam int SH    = 16 + T;
  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  localparam logic signed [PW-1:0] HALF = PW'(1) << (T - 1);
  localparam logic [VW-1:0]        TWO  = VW'(2) << T;
  localparam logic [VW-1:0]        FIVE = VW'(5) << T;

  typedef struct packed {
    logic [CHAR_W-1:0]  chr;
    logic [DEPTH_W-1:0] depth;
  } entry_t;

  entry_t mem [CELLS];
  entry_t rdata;

  logic signed [TRIG_W-1:0] c_r, l_r, f_r, d_r;
  logic [CELL_W-1:0]        idx_r;
  logic signed [VW-1:0]     h_r, ch_r, cd_r, fe_r, fg_r, lh_r, ld_r;
  logic signed [VW-1:0]     den_r, t_r, fcd_r, lum_r, xn_r, yn_r;
  logic signed [MBW-1:0]    rdx_r, rdy_r;
  logic [CW-1:0]            col_r;
  logic [RW-1:0]            row_r;
  logic                     col_ok, row_ok;

  logic signed [MAW-1:0]    ma;
  logic signed [MBW-1:0]    mb;
  logic signed [PW-1:0]     prod;
  logic                     wb_en;
  logic [STEP_W-1:0]        wb_step;
  logic signed [PW-1:0]     qsum, xs, ys, xv, yv;
  logic signed [VW-1:0]     q;

  logic [DIVW-1:0]          num, quo;
  logic                     div_done;
  logic [DEPTH_W-1:0]       dq;

  logic [AW-1:0]            sweep_addr, cell_addr, idx_addr, rd_addr, wr_addr;
  logic                     idx_ok, we, re;
  entry_t                   wd;
  logic signed [VW-1:0]     lsh;
  logic [3:0]               shade_idx;
  logic [CHAR_W-1:0]        new_chr;
  logic                     win;

  // inputs
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_r   <= tube_sine;
      l_r   <= tube_cosine;
      f_r   <= ring_sine;
      d_r   <= ring_cosine;
      h_r   <= VW'(ring_cosine) + TWO;
      idx_r <= cell_index;
    end
  end

  // shared multiplier operand selection
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.step)
      STEP_CH:   begin ma = MAW'(c_r);         mb = MBW'(h_r[MBW-1:0]); end
      STEP_CD:   begin ma = MAW'(c_r);         mb = MBW'(d_r);          end
      STEP_FE:   begin ma = MAW'(f_r);         mb = MBW'(cfg.a_sin);    end
      STEP_FG:   begin ma = MAW'(f_r);         mb = MBW'(cfg.a_cos);    end
      STEP_LH:   begin ma = MAW'(l_r);         mb = MBW'(h_r[MBW-1:0]); end
      STEP_LD:   begin ma = MAW'(l_r);         mb = MBW'(d_r);          end
      STEP_CHE:  begin ma = ch_r[MAW-1:0];     mb = MBW'(cfg.a_sin);    end
      STEP_CHG:  begin ma = ch_r[MAW-1:0];     mb = MBW'(cfg.a_cos);    end
      STEP_CDG:  begin ma = cd_r[MAW-1:0];     mb = MBW'(cfg.a_cos);    end
      STEP_CDE:  begin ma = cd_r[MAW-1:0];     mb = MBW'(cfg.a_sin);    end
      STEP_LDN:  begin ma = ld_r[MAW-1:0];     mb = MBW'(cfg.b_sin);    end
      STEP_LHM:  begin ma = lh_r[MAW-1:0];     mb = MBW'(cfg.b_cos);    end
      STEP_LHN:  begin ma = lh_r[MAW-1:0];     mb = MBW'(cfg.b_sin);    end
      STEP_TN:   begin ma = t_r[MAW-1:0];      mb = MBW'(cfg.b_sin);    end
      STEP_TM:   begin ma = t_r[MAW-1:0];      mb = MBW'(cfg.b_cos);    end
      STEP_FCDM: begin ma = fcd_r[MAW-1:0];    mb = MBW'(cfg.b_cos);    end
      STEP_RDX:  begin ma = MAW'(dq);          mb = MBW'(cfg.col_rad);  end
      STEP_RDY:  begin ma = MAW'(dq);          mb = MBW'(cfg.row_rad);  end
      STEP_PX:   begin ma = xn_r[MAW-1:0];     mb = rdx_r;              end
      STEP_PY:   begin ma = yn_r[MAW-1:0];     mb = rdy_r;              end
      default:   begin ma = '0;                mb = '0;                 end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      prod <= ma * mb;
    end
    wb_step <= cmd.step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_en <= 1'b0;
    end else begin
      wb_en <= cmd.issue;
    end
  end

  // round to nearest, then floor shift back to the trig scale
  assign qsum = prod + HALF;
  assign q    = VW'(qsum >>> T);
  assign xs   = prod + (PW'(cfg.col_off) << SH);
  assign ys   = prod + (PW'(cfg.row_off) << SH);
  assign xv   = xs >>> SH;
  assign yv   = ys >>> SH;

  always_ff @(posedge clk) begin
    if (wb_en) begin
      unique case (wb_step)
        STEP_CH:   ch_r  <= q;
        STEP_CD:   cd_r  <= q;
        STEP_FE:   fe_r  <= q;
        STEP_FG:   fg_r  <= q;
        STEP_LH:   lh_r  <= q;
        STEP_LD:   ld_r  <= q;
        STEP_CHE:  den_r <= q + fg_r + FIVE;
        STEP_CHG:  t_r   <= q - fe_r;
        STEP_CDG:  fcd_r <= fe_r - q;
        STEP_CDE:  lum_r <= -q - fg_r;
        STEP_LDN:  lum_r <= lum_r - q;
        STEP_LHM:  xn_r  <= q;
        STEP_LHN:  yn_r  <= q;
        STEP_TN:   xn_r  <= xn_r - q;
        STEP_TM:   yn_r  <= yn_r + q;
        STEP_FCDM: lum_r <= lum_r + q;
        STEP_RDX:  rdx_r <= prod[MBW-1:0];
        STEP_RDY:  rdy_r <= prod[MBW-1:0];
        STEP_PX: begin
          col_ok <= (xv > 0) && (xv < COLUMNS);
          col_r  <= xv[CW-1:0];
        end
        STEP_PY: begin
          row_ok <= (yv > 0) && (yv < ROWS);
          row_r  <= yv[RW-1:0];
        end
        default: ;
      endcase
    end
  end

  // reciprocal depth
  assign num = (DIVW'(1) << SH) + DIVW'(den_r >>> 1);

  tpzp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num),
    .den   (den_r[DIVW-1:0]),
    .quo   (quo),
    .done  (div_done)
  );

  assign dq = (|quo[DIVW-1:DEPTH_W]) ? {DEPTH_W{1'b1}} : quo[DEPTH_W-1:0];

  // luminance shade
  assign lsh = lum_r >>> (T - 3);
  always_comb begin
    if (lum_r <= 0) begin
      shade_idx = 4'd0;
    end else if (lsh > 11) begin
      shade_idx = 4'd11;
    end else begin
      shade_idx = lsh[3:0];
    end
  end
  assign new_chr = shade_char(shade_idx);

  // cell store
  assign cell_addr = AW'(col_r) + AW'(row_r * COLUMNS);
  assign idx_addr  = AW'(idx_r);
  assign idx_ok    = idx_r < CELLS;
  assign win       = dq > rdata.depth;

  always_comb begin
    rd_addr = (cmd.kind == FIN_PLOT) ? cell_addr : idx_addr;
    re      = cmd.rd && ((cmd.kind == FIN_PLOT) || idx_ok);
    we      = 1'b0;
    wr_addr = sweep_addr;
    wd      = '{chr: SPACE_CODE, depth: '0};
    if (cmd.sweep) begin
      we = 1'b1;
    end else if (cmd.fin && cmd.kind == FIN_PLOT && win) begin
      we      = 1'b1;
      wr_addr = cell_addr;
      wd      = '{chr: new_chr, depth: dq};
    end else if (cmd.fin && cmd.kind == FIN_CLEAR && idx_ok) begin
      we      = 1'b1;
      wr_addr = idx_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wd;
    end
    if (re) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (cmd.sweep) begin
      sweep_addr <= sweep_addr + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      unique case (cmd.kind)
        FIN_ZERO: begin
          plotted     <= 1'b0;
          target_cell <= '0;
          char_code   <= '0;
          cell_depth  <= '0;
        end
        FIN_PLOT: begin
          plotted     <= win;
          target_cell <= CELL_W'(cell_addr);
          char_code   <= win ? new_chr : rdata.chr;
          cell_depth  <= win ? dq : rdata.depth;
        end
        FIN_CLEAR: begin
          plotted     <= 1'b0;
          target_cell <= idx_r;
          char_code   <= SPACE_CODE;
          cell_depth  <= '0;
        end
        FIN_READ: begin
          plotted     <= 1'b0;
          target_cell <= idx_r;
          char_code   <= idx_ok ? rdata.chr : SPACE_CODE;
          cell_depth  <= idx_ok ? rdata.depth : '0;
        end
      endcase
    end
  end

  assign stat.den_pos    = den_r > 0;
  assign stat.div_done   = div_done;
  assign stat.cell_ok    = col_ok && row_ok;
  assign stat.sweep_last = sweep_addr == AW'(CELLS - 1);
  assign stat.out_free   = !out_valid || out_ready;

endmodule

/* rtl/tpzp_ctrl.sv */
// ----------------------------------------------------------------------------
// tpzp_ctrl
// Sequencer for store sweep, plot multiply steps, divide wait and store access.
// ----------------------------------------------------------------------------
module tpzp_ctrl import tpzp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  opcode_t  in_opcode,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_SWEEP = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MUL   = 6'b000100,
    S_DIV   = 6'b001000,
    S_RD    = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;
  fin_kind_t         kind, kind_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      step  <= '0;
      kind  <= FIN_ZERO;
    end else begin
      state <= state_next;
      step  <= step_next;
      kind  <= kind_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    kind_next  = kind;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.kind   = kind;
    cmd.step   = step;
    unique case (state)
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (in_opcode)
            OP_PLOT: begin
              step_next  = STEP_CH;
              state_next = S_MUL;
            end
            OP_CLEAR: begin
              kind_next  = FIN_CLEAR;
              state_next = S_RD;
            end
            OP_READ: begin
              kind_next  = FIN_READ;
              state_next = S_RD;
            end
            OP_NONE: begin
              kind_next  = FIN_ZERO;
              state_next = S_FIN;
            end
          endcase
        end
      end
      S_MUL: begin
        cmd.issue     = (step <= STEP_FCDM) || (step >= STEP_RDX && step <= STEP_PY);
        cmd.div_start = step == STEP_DIV_START;
        if (step == STEP_DRAIN_A) begin
          if (stat.den_pos) begin
            state_next = S_DIV;
          end else begin
            kind_next  = FIN_ZERO;
            state_next = S_FIN;
          end
        end else if (step == STEP_END) begin
          if (stat.cell_ok) begin
            kind_next  = FIN_PLOT;
            state_next = S_RD;
          end else begin
            kind_next  = FIN_ZERO;
            state_next = S_FIN;
          end
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          step_next  = STEP_RDX;
          state_next = S_MUL;
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_SWEEP;
    endcase
  end

endmodule

/* rtl/torus_point_zbuffer_plotter.sv */
// ----------------------------------------------------------------------------
// torus_point_zbuffer_plotter
// Torus sample projector with a depth-tested character grid.
// ----------------------------------------------------------------------------
// After reset the block sweeps all COLUMNS*ROWS cells of the character store
// (1100 by default) to spaces and zero depth before it takes its first beat. A
// plot beat that reaches the store goes through sixteen steps on the shared
// multiplier, then a 34-bit bit-serial divide for the reciprocal depth (started
// mid way through the multiply steps), the projection products, a store read
// and the update. A plot with a non-positive denominator ends after the
// sixteen multiply steps, one whose cell falls outside the grid after the
// projection products. Clear and read beats go through a store read before
// their result is registered. One beat is in flight at a time; the result
// register lets the next beat in while a result waits to be taken.
module torus_point_zbuffer_plotter import tpzp_pkg::*; #(
  parameter int COLUMNS        = 50,
  parameter int ROWS           = 22,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic          clk,
  input  logic          rst,
  tpzp_sample_if.sink   sample_in,
  tpzp_result_if.source result_out,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.a_sin   <= 16'sd0;
      cfg.a_cos   <= 16'sd16384;
      cfg.b_sin   <= 16'sd0;
      cfg.b_cos   <= 16'sd16384;
      cfg.col_off <= 6'd20;
      cfg.col_rad <= 6'd25;
      cfg.row_off <= 5'd12;
      cfg.row_rad <= 5'd15;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_ROT_A_SINE:   cfg.a_sin   <= pwdata[15:0];
        REG_ROT_A_COSINE: cfg.a_cos   <= pwdata[15:0];
        REG_ROT_B_SINE:   cfg.b_sin   <= pwdata[15:0];
        REG_ROT_B_COSINE: cfg.b_cos   <= pwdata[15:0];
        REG_COL_OFFSET:   cfg.col_off <= pwdata[5:0];
        REG_COL_RADIUS:   cfg.col_rad <= pwdata[5:0];
        REG_ROW_OFFSET:   cfg.row_off <= pwdata[4:0];
        REG_ROW_RADIUS:   cfg.row_rad <= pwdata[4:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_ROT_A_SINE:   prdata = 32'(cfg.a_sin);
      REG_ROT_A_COSINE: prdata = 32'(cfg.a_cos);
      REG_ROT_B_SINE:   prdata = 32'(cfg.b_sin);
      REG_ROT_B_COSINE: prdata = 32'(cfg.b_cos);
      REG_COL_OFFSET:   prdata = 32'(cfg.col_off);
      REG_COL_RADIUS:   prdata = 32'(cfg.col_rad);
      REG_ROW_OFFSET:   prdata = 32'(cfg.row_off);
      REG_ROW_RADIUS:   prdata = 32'(cfg.row_rad);
    endcase
  end

  tpzp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample_in.valid),
    .in_opcode (opcode_t'(sample_in.opcode)),
    .in_ready  (sample_in.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tpzp_dp #(
    .COLUMNS        (COLUMNS),
    .ROWS           (ROWS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg         (cfg),
    .tube_sine   (sample_in.tube_sine),
    .tube_cosine (sample_in.tube_cosine),
    .ring_sine   (sample_in.ring_sine),
    .ring_cosine (sample_in.ring_cosine),
    .cell_index  (sample_in.cell_index),
    .out_ready   (result_out.ready),
    .out_valid   (result_out.valid),
    .plotted     (result_out.plotted),
    .target_cell (result_out.target_cell),
    .char_code   (result_out.char_code),
    .cell_depth  (result_out.cell_depth)
  );

endmodule

/* rtl/tpzp_checker.sv */
// ----------------------------------------------------------------------------
// tpzp_checker
// Port-level checks for the torus point plotter, bound to the top level.
// ----------------------------------------------------------------------------
module tpzp_checker import tpzp_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               plotted,
  input logic [CELL_W-1:0]  target_cell,
  input logic [CHAR_W-1:0]  char_code,
  input logic [DEPTH_W-1:0] cell_depth
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable({plotted, target_cell, char_code, cell_depth}))
    else $error("result changed while stalled");

  // store sweep keeps the input closed after reset
  a_sweep_closed: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input open during store sweep");

  // one beat in flight at a time
  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // a winning plot lands inside the grid with a nonzero depth
  a_plot_sane: assert property (@(posedge clk) disable iff (rst)
    out_valid && plotted |-> cell_depth != '0 && target_cell != '0)
    else $error("plotted beat with empty cell");

endmodule

bind torus_point_zbuffer_plotter tpzp_checker u_tpzp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (sample_in.valid),
  .in_ready    (sample_in.ready),
  .out_valid   (result_out.valid),
  .out_ready   (result_out.ready),
  .plotted     (result_out.plotted),
  .target_cell (result_out.target_cell),
  .char_code   (result_out.char_code),
  .cell_depth  (result_out.cell_depth)
);
